@@ rtl/core/trsp_pkg.sv @@
package trsp_pkg;

    // Sizes of the frame table
    localparam int MAX_FRAMES_DEF = 1024;
    localparam int TIME_W         = 32;
    localparam int FRAME_CNT_W    = 11;
    localparam int SLOT_W         = 10;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Register map, word index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_FRAME_COUNT   = 2'd0,
        REG_LOOP_ENABLE   = 2'd1,
        REG_STARTUP_DELAY = 2'd2,
        REG_TICK_MS       = 2'd3
    } reg_idx_t;

    localparam logic [10:0] FRAME_COUNT_RST   = 11'd1;
    localparam logic        LOOP_ENABLE_RST   = 1'b0;
    localparam logic [15:0] STARTUP_DELAY_RST = 16'd2000;
    localparam logic [7:0]  TICK_MS_RST       = 8'd8;

    // Neutral report values
    localparam logic [3:0] HAT_CENTER   = 4'd8;
    localparam logic [7:0] AXIS_NEUTRAL = 8'h80;

    // Parity of clock/500: (clock>>2)/125 == ((clock>>2) * LED_RECIP) >> LED_SHIFT,
    // exact for every 30-bit operand
    localparam logic [30:0] LED_RECIP = 31'd1099511628;
    localparam int          LED_SHIFT = 37;

    typedef struct packed {
        logic [10:0] frame_count;
        logic        loop_enable;
        logic [15:0] startup_delay_ms;
        logic [7:0]  tick_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [15:0] buttons;
        logic [7:0]  hat;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
    } frame_entry_t;

    typedef struct packed {
        logic [7:0] button_low_byte;
        logic [7:0] button_high_byte;
        logic [3:0] hat_out;
        logic [7:0] left_x_out;
        logic [7:0] left_y_out;
        logic [7:0] right_x_out;
        logic [7:0] right_y_out;
        logic       led_on;
        logic       in_startup;
    } report_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK_LAST,
        ST_SCAN,
        ST_EMIT
    } seq_state_t;

endpackage

@@ rtl/core/timed_report_sequence_player.sv @@
// Channel   | Handshake                         | Word
// ----------+-----------------------------------+---------------------------------------------
// request   | start, taken when busy is low     | req_type, frame_index, frame_time_ms,
//           |                                   | frame_buttons, frame_hat, frame_left/right_x/y
// report    | done, one-cycle strobe            | button_low/high_byte, hat_out, axes, led_on,
//           |                                   | in_startup
// config    | APB write, psel&penable&pwrite    | pwdata at paddr = 4*register index
//
// A load word writes the frame table at the accept edge.
// A tick during the startup delay stays in the idle state; its report follows in the cycle after.
// A playback tick steps through PREP, which reads the last frame, and CHECK_LAST, which reports
// when the last frame is held; else it goes on to EMIT when no scan is needed, or to SCAN, which
// steps past table entries (one table read per cycle on the single read port) before EMIT.
// Reset clears the control state only; the frame table holds garbage until loaded.
// Reports cannot be stalled: done is high for exactly one cycle per report.
module timed_report_sequence_player
    import trsp_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [9:0]  frame_index,
    input  logic [31:0] frame_time_ms,
    input  logic [15:0] frame_buttons,
    input  logic [7:0]  frame_hat,
    input  logic [7:0]  frame_left_x,
    input  logic [7:0]  frame_left_y,
    input  logic [7:0]  frame_right_x,
    input  logic [7:0]  frame_right_y,
    // report
    output logic        done,
    output logic [7:0]  button_low_byte,
    output logic [7:0]  button_high_byte,
    output logic [3:0]  hat_out,
    output logic [7:0]  left_x_out,
    output logic [7:0]  left_y_out,
    output logic [7:0]  right_x_out,
    output logic [7:0]  right_y_out,
    output logic        led_on,
    output logic        in_startup,
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(MAX_FRAMES);
    // wide enough for frame_count, the slot field and MAX_FRAMES itself
    localparam int CW = (IW + 1 > FRAME_CNT_W) ? IW + 1 : FRAME_CNT_W;

    cfg_t cfg;

    trsp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    seq_state_t      state_reg, state_next;
    logic [31:0]     clock_reg, clock_next;
    logic [31:0]     play_start_reg, play_start_next;
    logic [31:0]     elapsed_reg, elapsed_next;
    logic [IW-1:0]   index_reg, index_next;
    logic            started_reg, started_next;
    logic            fin_reg, fin_next;
    logic            done_reg, done_next;
    report_t         rpt_reg, rpt_next;

    // ------------------------------------------------------------------
    // Frame table: loads only land while idle, reads only happen mid-tick,
    // so a write and a read never overlap on the same entry.
    // ------------------------------------------------------------------
    logic            mem_we;
    logic            mem_re;
    logic [IW-1:0]   mem_raddr;
    logic [CW-1:0]   slot_ext;
    logic            slot_ok;
    frame_entry_t    wr_entry;
    frame_entry_t    rd_entry;

    assign slot_ext = CW'(frame_index);
    assign slot_ok  = slot_ext < CW'(MAX_FRAMES);

    assign wr_entry.time_ms = frame_time_ms;
    assign wr_entry.buttons = frame_buttons;
    assign wr_entry.hat     = frame_hat;
    assign wr_entry.left_x  = frame_left_x;
    assign wr_entry.left_y  = frame_left_y;
    assign wr_entry.right_x = frame_right_x;
    assign wr_entry.right_y = frame_right_y;

    trsp_table #(
        .DEPTH (MAX_FRAMES),
        .AW    (IW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_ext[IW-1:0]),
        .wdata (wr_entry),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_entry)
    );

    // LED parity tracks clock_reg; valid in the cycle after the clock settles
    logic led_odd;

    trsp_led u_led (
        .clk      (clk),
        .clock_ms (clock_reg),
        .led_odd  (led_odd)
    );

    // ------------------------------------------------------------------
    // Last playable frame: count of zero plays one frame, large counts saturate
    // ------------------------------------------------------------------
    logic [CW-1:0] fc_ext;
    logic [CW-1:0] count;
    logic [CW-1:0] count_m1;
    logic [IW-1:0] last;

    assign fc_ext   = CW'(cfg.frame_count);
    assign count    = (fc_ext == '0) ? CW'(1) :
                      ((fc_ext > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : fc_ext);
    assign count_m1 = count - CW'(1);
    assign last     = count_m1[IW-1:0];

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic          accept;
    logic [31:0]   clock_tick;
    logic [31:0]   clock_play;
    logic          in_delay;
    logic          last_due;
    logic          restart;
    logic [IW-1:0] scan_base;
    logic [IW-1:0] scan_base_inc;
    logic [IW-1:0] index_inc;
    logic [IW-1:0] index_inc2;
    logic          scan_hit;
    report_t       rpt_frame;
    report_t       rpt_neutral;

    assign accept     = start && (state_reg == ST_IDLE);
    assign clock_tick = clock_reg + 32'(cfg.tick_ms);
    // first playback tick restarts the clock from zero, setting it to tick_ms
    assign clock_play = fin_reg ? clock_tick : 32'(cfg.tick_ms);
    assign in_delay   = !fin_reg && (clock_reg < 32'(cfg.startup_delay_ms));

    assign last_due      = (index_reg >= last) && (elapsed_reg >= rd_entry.time_ms);
    assign restart       = last_due && cfg.loop_enable;
    assign scan_base     = restart ? '0 : index_reg;
    assign scan_base_inc = scan_base + IW'(1);
    assign index_inc     = index_reg + IW'(1);
    assign index_inc2    = index_inc + IW'(1);
    assign scan_hit      = elapsed_reg >= rd_entry.time_ms;

    // report from the entry on the read port
    always_comb
    begin
        rpt_frame.button_low_byte  = rd_entry.buttons[7:0];
        rpt_frame.button_high_byte = rd_entry.buttons[15:8];
        rpt_frame.hat_out          = (rd_entry.hat > 8'(HAT_CENTER)) ? HAT_CENTER
                                                                     : rd_entry.hat[3:0];
        rpt_frame.left_x_out       = rd_entry.left_x;
        rpt_frame.left_y_out       = rd_entry.left_y;
        rpt_frame.right_x_out      = rd_entry.right_x;
        rpt_frame.right_y_out      = rd_entry.right_y;
        rpt_frame.led_on           = cfg.loop_enable ? led_odd : 1'b1;
        rpt_frame.in_startup       = 1'b0;
    end

    always_comb
    begin
        rpt_neutral.button_low_byte  = 8'h00;
        rpt_neutral.button_high_byte = 8'h00;
        rpt_neutral.hat_out          = HAT_CENTER;
        rpt_neutral.left_x_out       = AXIS_NEUTRAL;
        rpt_neutral.left_y_out       = AXIS_NEUTRAL;
        rpt_neutral.right_x_out      = AXIS_NEUTRAL;
        rpt_neutral.right_y_out      = AXIS_NEUTRAL;
        rpt_neutral.led_on           = 1'b0;
        rpt_neutral.in_startup       = 1'b1;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        clock_next      = clock_reg;
        play_start_next = play_start_reg;
        elapsed_next    = elapsed_reg;
        index_next      = index_reg;
        started_next    = started_reg;
        fin_next        = fin_reg;
        done_next       = 1'b0;
        rpt_next        = rpt_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = index_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        // drop loads aimed past the table
                        mem_we = slot_ok;
                    end
                    else if (in_delay)
                    begin
                        clock_next = clock_tick;
                        done_next  = 1'b1;
                        rpt_next   = rpt_neutral;
                    end
                    else
                    begin
                        fin_next   = 1'b1;
                        clock_next = clock_play;
                        if (!started_reg)
                        begin
                            started_next    = 1'b1;
                            play_start_next = clock_play;
                            index_next      = '0;
                        end
                        state_next = ST_PREP;
                    end
                end
            end

            ST_PREP:
            begin
                // fetch the last frame's timestamp
                elapsed_next = clock_reg - play_start_reg;
                mem_re       = 1'b1;
                mem_raddr    = last;
                state_next   = ST_CHECK_LAST;
            end

            ST_CHECK_LAST:
            begin
                if (last_due && !cfg.loop_enable)
                begin
                    // hold the last frame
                    done_next  = 1'b1;
                    rpt_next   = rpt_frame;
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (restart)
                    begin
                        index_next      = '0;
                        play_start_next = clock_reg;
                        elapsed_next    = '0;
                    end
                    mem_re = 1'b1;
                    if (scan_base < last)
                    begin
                        mem_raddr  = scan_base_inc;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        mem_raddr  = scan_base;
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_SCAN:
            begin
                // read port holds entry index_reg + 1
                mem_re = 1'b1;
                if (scan_hit)
                begin
                    index_next = index_inc;
                    if (index_inc < last)
                    begin
                        mem_raddr = index_inc2;
                    end
                    else
                    begin
                        mem_raddr  = index_inc;
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    mem_raddr  = index_reg;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                done_next  = 1'b1;
                rpt_next   = rpt_frame;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clock_reg      <= '0;
            play_start_reg <= '0;
            elapsed_reg    <= '0;
            index_reg      <= '0;
            started_reg    <= 1'b0;
            fin_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clock_reg      <= clock_next;
            play_start_reg <= play_start_next;
            elapsed_reg    <= elapsed_next;
            index_reg      <= index_next;
            started_reg    <= started_next;
            fin_reg        <= fin_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rpt_reg <= rpt_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign button_low_byte  = rpt_reg.button_low_byte;
    assign button_high_byte = rpt_reg.button_high_byte;
    assign hat_out          = rpt_reg.hat_out;
    assign left_x_out       = rpt_reg.left_x_out;
    assign left_y_out       = rpt_reg.left_y_out;
    assign right_x_out      = rpt_reg.right_x_out;
    assign right_y_out      = rpt_reg.right_y_out;
    assign led_on           = rpt_reg.led_on;
    assign in_startup       = rpt_reg.in_startup;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_load_no_report: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_LOAD) |=> !done)
        else $error("report issued for a load word");

    a_idle_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> $stable(index_reg))
        else $error("playback index moved outside a tick");

    a_neutral_in_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_startup) |-> !fin_reg)
        else $error("neutral report after startup ended");

    a_clock_restart: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fin_reg) |-> (clock_reg == 32'(cfg.tick_ms)))
        else $error("clock not restarted at end of startup");

endmodule

@@ rtl/core/trsp_cfg.sv @@
module trsp_cfg
    import trsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_FRAME_COUNT:   cfg_next.frame_count      = pwdata[10:0];
                REG_LOOP_ENABLE:   cfg_next.loop_enable      = pwdata[0];
                REG_STARTUP_DELAY: cfg_next.startup_delay_ms = pwdata[15:0];
                REG_TICK_MS:       cfg_next.tick_ms          = pwdata[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_count      <= FRAME_COUNT_RST;
            cfg_reg.loop_enable      <= LOOP_ENABLE_RST;
            cfg_reg.startup_delay_ms <= STARTUP_DELAY_RST;
            cfg_reg.tick_ms          <= TICK_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_FRAME_COUNT:   prdata = {21'b0, cfg_reg.frame_count};
            REG_LOOP_ENABLE:   prdata = {31'b0, cfg_reg.loop_enable};
            REG_STARTUP_DELAY: prdata = {16'b0, cfg_reg.startup_delay_ms};
            REG_TICK_MS:       prdata = {24'b0, cfg_reg.tick_ms};
        endcase
    end

endmodule

@@ rtl/core/trsp_table.sv @@
module trsp_table
    import trsp_pkg::*;
#(
    parameter int DEPTH = MAX_FRAMES_DEF,
    parameter int AW    = $clog2(MAX_FRAMES_DEF)
)
(
    input  logic         clk,
    input  logic         we,
    input  logic [AW-1:0] waddr,
    input  frame_entry_t wdata,
    input  logic         re,
    input  logic [AW-1:0] raddr,
    output frame_entry_t rdata
);

    frame_entry_t entry_mem [DEPTH];
    frame_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= entry_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/trsp_led.sv @@
module trsp_led
    import trsp_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] clock_ms,
    output logic        led_odd
);

    logic [60:0] prod;
    logic        odd_reg;

    // quotient by 500 via reciprocal; only its low bit is kept
    assign prod = {31'b0, clock_ms[31:2]} * {30'b0, LED_RECIP};

    always_ff @(posedge clk)
    begin
        odd_reg <= prod[LED_SHIFT];
    end

    assign led_odd = odd_reg;

endmodule
